@@ rtl/core/bcu_pkg.sv @@
// Shared constants and types for the binomial coefficient unit.
package bcu_pkg;

  localparam int unsigned MAX_N     = 61;
  localparam int unsigned IN_W      = 8;   // width of n_total and k_chosen
  localparam int unsigned N_W       = 6;   // width of an accepted n (0..MAX_N)
  localparam int unsigned K_W       = 5;   // width of min(k, n-k)
  localparam int unsigned ACC_W     = 64;  // running product
  localparam int unsigned COEF_W    = 63;
  localparam int unsigned S_DATA_W  = 16;
  localparam int unsigned M_DATA_W  = 64;
  localparam int unsigned BIT_CNT_W = 3;   // indexes the N_W bits of a factor
  localparam int unsigned DIV_CNT_W = 6;   // indexes the ACC_W dividend bits

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_NEG  = 2'd1,
    ST_OVER = 2'd2
  } status_t;

endpackage

@@ rtl/core/binomial_coefficient_unit.sv @@
// Binomial coefficient unit: bit-serial multiply and exact divide sequencer.
//
// Usage: present n_total in s_tdata[7:0] and k_chosen in s_tdata[15:8] with
// s_tvalid; the transaction is taken when s_tready is high. One result
// transaction follows on the master side: C(n,k) in m_tdata and a status
// code in m_tuser (0 ok, 1 negative operand, 2 n above 61).
// Errors and k > n give a zero coefficient.
// Sequence: a trivial case (error, k > n, min(k, n-k) = 0) skips the rounds
// and goes straight to the done state. Otherwise the unit runs min(k, n-k)
// rounds: a shift-add multiply by (n-k+i), one multiplier bit per cycle,
// then a restoring division by i, one quotient bit per cycle. Worst case is
// 30 rounds. One item is in work at a time; s_tready is high only while the
// sequencer is idle.
// The result sits in an output register: a stalled receiver (m_tready low)
// holds m_tvalid and the payload, and the unit may already accept and work
// on the next item; it waits to deliver until the register is free.
// Reset (rst, synchronous) returns the sequencer to idle and drops m_tvalid.
module binomial_coefficient_unit
  import bcu_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [S_DATA_W-1:0] s_tdata,   // [7:0] n_total, [15:8] k_chosen
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [M_DATA_W-1:0] m_tdata,   // [62:0] coefficient, [63] zero
  output logic [1:0]          m_tuser    // [1:0] status
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_DIV,
    S_DONE
  } state_t;

  state_t                 state;
  logic [ACC_W-1:0]       acc;
  logic [ACC_W-1:0]       work;
  logic [N_W-1:0]         mult;
  logic [N_W-1:0]         n_val;
  logic [K_W-1:0]         k_min;
  logic [K_W-1:0]         idx;
  logic [BIT_CNT_W-1:0]   bit_cnt;
  logic [DIV_CNT_W-1:0]   div_cnt;
  logic [K_W-1:0]         rem;
  status_t                status;
  logic [COEF_W-1:0]      coef_out;
  status_t                status_out;

  // Input decode
  logic [IN_W-1:0] n_in;
  logic [IN_W-1:0] k_in;
  logic            neg;
  logic            over;
  logic            k_gt_n;
  logic [N_W-1:0]  n_minus_k;
  logic [K_W-1:0]  k_min_in;

  assign n_in      = s_tdata[IN_W-1:0];
  assign k_in      = s_tdata[2*IN_W-1:IN_W];
  assign neg       = n_in[IN_W-1] | k_in[IN_W-1];
  assign over      = n_in[IN_W-2:0] > (IN_W-1)'(MAX_N);
  assign k_gt_n    = k_in[IN_W-2:0] > n_in[IN_W-2:0];
  assign n_minus_k = n_in[N_W-1:0] - k_in[N_W-1:0];
  assign k_min_in  = (k_in[N_W-1:0] > n_minus_k) ? n_minus_k[K_W-1:0] : k_in[K_W-1:0];

  // Datapath steps
  logic [ACC_W-1:0] mul_next;
  logic [K_W:0]     trial;
  logic             q_bit;
  logic [K_W-1:0]   rem_next;
  logic [ACC_W-1:0] quot_next;
  logic [K_W-1:0]   idx_inc;
  logic [N_W-1:0]   mult_next;
  logic             out_free;

  assign mul_next  = {work[ACC_W-2:0], 1'b0} + (mult[bit_cnt] ? acc : '0);
  assign trial     = {rem, work[ACC_W-1]};
  assign q_bit     = trial >= {1'b0, idx};
  assign rem_next  = q_bit ? K_W'(trial - {1'b0, idx}) : trial[K_W-1:0];
  assign quot_next = {work[ACC_W-2:0], q_bit};
  assign idx_inc   = idx + K_W'(1);
  assign mult_next = n_val - {1'b0, k_min} + {1'b0, idx_inc};
  assign out_free  = !m_tvalid || m_tready;

  assign s_tready = (state == S_IDLE);
  assign m_tdata  = {1'b0, coef_out};
  assign m_tuser  = status_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if (state == S_DONE && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            n_val <= n_in[N_W-1:0];
            k_min <= k_min_in;
            idx   <= K_W'(1);
            work  <= '0;
            bit_cnt <= BIT_CNT_W'(N_W - 1);
            mult  <= n_in[N_W-1:0] - {1'b0, k_min_in} + N_W'(1);
            if (neg) begin
              status <= ST_NEG;
              acc    <= '0;
              state  <= S_DONE;
            end else if (over) begin
              status <= ST_OVER;
              acc    <= '0;
              state  <= S_DONE;
            end else if (k_gt_n) begin
              status <= ST_OK;
              acc    <= '0;
              state  <= S_DONE;
            end else begin
              status <= ST_OK;
              acc    <= ACC_W'(1);
              state  <= (k_min_in == '0) ? S_DONE : S_MUL;
            end
          end
        end
        S_MUL: begin
          // MSB-first shift-add of acc times mult
          work <= mul_next;
          if (bit_cnt == '0) begin
            div_cnt <= DIV_CNT_W'(ACC_W - 1);
            rem     <= '0;
            state   <= S_DIV;
          end else begin
            bit_cnt <= bit_cnt - BIT_CNT_W'(1);
          end
        end
        S_DIV: begin
          // restoring division by idx, quotient shifts in behind the dividend
          rem  <= rem_next;
          if (div_cnt == '0) begin
            acc <= quot_next;
            if (idx == k_min) begin
              state <= S_DONE;
            end else begin
              idx     <= idx_inc;
              mult    <= mult_next;
              work    <= '0;
              bit_cnt <= BIT_CNT_W'(N_W - 1);
              state   <= S_MUL;
            end
          end else begin
            work    <= quot_next;
            div_cnt <= div_cnt - DIV_CNT_W'(1);
          end
        end
        S_DONE: begin
          if (out_free) begin
            coef_out   <= acc[COEF_W-1:0];
            status_out <= status;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ rtl/core/bcu_checker.sv @@
// Port-level checker for the binomial coefficient unit, bound to the top level.
module bcu_checker
  import bcu_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                s_tvalid,
  input logic                s_tready,
  input logic                m_tvalid,
  input logic                m_tready,
  input logic [M_DATA_W-1:0] m_tdata,
  input logic [1:0]          m_tuser
);

  // Never report the unused status code.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser == ST_OK || m_tuser == ST_NEG || m_tuser == ST_OVER))
    else $error("reserved status code on output");

  // An error status always carries a zero coefficient.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser != ST_OK) |-> (m_tdata == '0))
    else $error("nonzero coefficient with error status");

  // Hold a stalled result transaction.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("stalled result changed");

  // Take one input transaction at a time.
  assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input accepted while busy");

  // Reset drops the output.
  assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("m_tvalid high after reset");

endmodule

bind binomial_coefficient_unit bcu_checker u_bcu_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the binomial coefficient unit: directed table, then random stream.
module testbench;
  import bcu_pkg::*;

  localparam int RANDOM_ITEMS = 270;
  localparam int HOLD_CYCLES  = 6000;    // long receiver stall, fills the unit
  localparam int DRAIN_CYCLES = 2200;    // wait after the last expected result, catches stray outputs
  localparam int CYCLE_LIMIT  = 3000000;

  typedef struct packed {
    logic [COEF_W-1:0] coef;
    status_t           st;
  } coef_result_t;

  typedef struct packed {
    logic [7:0]        n;
    logic [7:0]        k;
    bit                known;            // expectation typed in below
    logic [COEF_W-1:0] coef;
    status_t           st;
  } directed_row_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [S_DATA_W-1:0] s_tdata = '0;     // [7:0] n_total, [15:8] k_chosen
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [M_DATA_W-1:0] m_tdata;          // [62:0] coefficient, [63] zero
  logic [1:0]          m_tuser;          // [1:0] status

  coef_result_t pending_coefficients[$];
  int           items_taken = 0;
  int           errors = 0;
  int           burst_left = 0;
  int           cycles = 0;
  bit           row_known = 1'b0;
  coef_result_t row_want = '0;

  directed_row_t directed_rows [0:20] = '{
    '{8'd0,   8'd0,   1'b1, 63'd1,  ST_OK},
    '{8'd61,  8'd0,   1'b1, 63'd1,  ST_OK},
    '{8'd61,  8'd61,  1'b1, 63'd1,  ST_OK},
    '{8'd61,  8'd1,   1'b1, 63'd61, ST_OK},
    '{8'd61,  8'd60,  1'b1, 63'd61, ST_OK},
    '{8'd61,  8'd30,  1'b0, 63'd0,  ST_OK},
    '{8'd61,  8'd31,  1'b0, 63'd0,  ST_OK},
    '{8'd60,  8'd30,  1'b0, 63'd0,  ST_OK},
    '{8'd10,  8'd3,   1'b0, 63'd0,  ST_OK},
    '{8'd1,   8'd1,   1'b1, 63'd1,  ST_OK},
    '{8'd5,   8'd6,   1'b1, 63'd0,  ST_OK},
    '{8'd0,   8'd127, 1'b1, 63'd0,  ST_OK},
    '{8'd62,  8'd0,   1'b1, 63'd0,  ST_OVER},
    '{8'd62,  8'd100, 1'b1, 63'd0,  ST_OVER},
    '{8'd127, 8'd127, 1'b1, 63'd0,  ST_OVER},
    '{8'hFF,  8'd0,   1'b1, 63'd0,  ST_NEG},
    '{8'd0,   8'hFF,  1'b1, 63'd0,  ST_NEG},
    '{8'h80,  8'h80,  1'b1, 63'd0,  ST_NEG},
    '{8'd127, 8'hFF,  1'b1, 63'd0,  ST_NEG},
    '{8'h80,  8'd127, 1'b1, 63'd0,  ST_NEG},
    '{8'd33,  8'd16,  1'b0, 63'd0,  ST_OK}
  };

  binomial_coefficient_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Multiplicative C(n,k) with a 64-bit running product and exact division.
  function automatic coef_result_t choose_coefficient(input logic [7:0] n_raw,
                                                      input logic [7:0] k_raw);
    coef_result_t      r;
    logic signed [7:0] n;
    logic signed [7:0] k;
    logic [63:0]       prod;
    int unsigned       nn;
    int unsigned       kk;
    int unsigned       i;
    n      = n_raw;
    k      = k_raw;
    r.coef = '0;
    r.st   = ST_OK;
    prod   = 64'd1;
    if (n < 0 || k < 0) begin
      r.st = ST_NEG;
    end else if (int'(n) > int'(MAX_N)) begin
      r.st = ST_OVER;
    end else if (k <= n) begin
      nn = int'(n);
      kk = int'(k);
      if (kk > nn - kk) kk = nn - kk;
      for (i = 1; i <= kk; i++) prod = prod * 64'(nn - kk + i) / 64'(i);
      r.coef = prod[COEF_W-1:0];
    end
    return r;
  endfunction

  // Present one item, with a random gap first when the current burst is used up.
  task automatic offer(input logic [7:0] n, input logic [7:0] k, input bit known,
                       input coef_result_t want);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 15);
      burst_left = ($urandom_range(7) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
      @(negedge clk);
      s_tvalid <= 1'b0;
      s_tdata  <= 16'($urandom);         // noise while idle
      repeat (gap - 1) @(negedge clk);
    end
    burst_left--;
    @(negedge clk);
    s_tvalid  <= 1'b1;
    s_tdata   <= {k, n};
    row_known = known;
    row_want  = want;
    do @(posedge clk); while (!s_tready);
  endtask

  // Record predictions on input transactions, check output transactions.
  always @(posedge clk) begin
    coef_result_t want;
    coef_result_t got;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got.coef = m_tdata[COEF_W-1:0];
        got.st   = status_t'(m_tuser);
        if (pending_coefficients.size() == 0) begin
          $display("%0t: unexpected result coef=%0d status=%0d", $time, got.coef, m_tuser);
          errors++;
        end else begin
          want = pending_coefficients.pop_front();
          if (got.coef !== want.coef) begin
            $display("%0t: coefficient mismatch expected=%0d actual=%0d",
                     $time, want.coef, got.coef);
            errors++;
          end
          if (m_tuser !== want.st) begin
            $display("%0t: status mismatch expected=%0d actual=%0d",
                     $time, want.st, m_tuser);
            errors++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        items_taken++;
        if (row_known) pending_coefficients.push_back(row_want);
        else pending_coefficients.push_back(choose_coefficient(s_tdata[7:0], s_tdata[15:8]));
      end
    end
  end

  // Receiver: changing stall patterns, plus one long hold-off.
  initial begin
    int cyc;
    int mode;
    bit held;
    cyc  = 0;
    mode = 0;
    held = 1'b0;
    while (rst) @(negedge clk);
    forever begin
      @(negedge clk);
      if (!held && items_taken >= 80) begin
        held = 1'b1;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else begin
        if (cyc % 50 == 0) mode = $urandom_range(2);
        case (mode)
          0: m_tready <= 1'b1;
          1: m_tready <= ($urandom_range(9) < 6);
          default: m_tready <= ((cyc % 7) < 4);
        endcase
        cyc++;
      end
    end
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin
    int         i;
    int         pick;
    logic [7:0] rn;
    logic [7:0] rk;
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[r])
      offer(directed_rows[r].n, directed_rows[r].k, directed_rows[r].known,
            '{directed_rows[r].coef, directed_rows[r].st});

    for (i = 0; i < RANDOM_ITEMS; i++) begin
      pick = $urandom_range(99);
      if (pick < 30) begin
        rn = 8'($urandom_range(MAX_N));
        rk = 8'($urandom_range(rn));
      end else if (pick < 55) begin
        rn = 8'($urandom_range(15));
        rk = 8'($urandom_range(rn));
      end else if (pick < 67) begin
        // k above n
        rn = 8'($urandom_range(MAX_N - 1));
        rk = 8'($urandom_range(rn + 1, 127));
      end else if (pick < 79) begin
        // oversized n, any k
        rn = 8'($urandom_range(MAX_N + 1, 127));
        rk = 8'($urandom);
      end else if (pick < 92) begin
        // at least one negative operand
        rn = 8'($urandom);
        rk = 8'($urandom);
        case ($urandom_range(2))
          0: rn[7] = 1'b1;
          1: rk[7] = 1'b1;
          default: begin
            rn[7] = 1'b1;
            rk[7] = 1'b1;
          end
        endcase
      end else begin
        rn = 8'($urandom);
        rk = 8'($urandom);
      end
      offer(rn, rk, 1'b0, '0);
    end
    @(negedge clk);
    s_tvalid <= 1'b0;

    while (pending_coefficients.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0 && pending_coefficients.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
